### hw/rtl/gn3d_pkg.sv
package gn3d_pkg;

    // Codes carried in tuser.
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_EVAL = 1'b1;

    localparam int CELL_W      = 8;
    localparam int TABLE_DEPTH = 256;
    localparam int NUM_COPIES  = 7;

    localparam int SCALE_W = 24;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;

    localparam int COORD_W   = 32;
    localparam int PROD_W    = 57;
    localparam int S_TDATA_W = 112;
    localparam int OUT_W     = 18;
    localparam int M_TDATA_W = 24;

    localparam int OUT_MAX_C = 131071;
    localparam int OUT_MIN_C = -131072;

    // Gradient selection points on the low four hash bits.
    localparam logic [3:0] HASH_U_SPLIT = 4'd8;
    localparam logic [3:0] HASH_V_SPLIT = 4'd4;
    localparam logic [3:0] HASH_V_X_A   = 4'd12;
    localparam logic [3:0] HASH_V_X_B   = 4'd14;

    typedef logic [CELL_W-1:0] cell_t;

endpackage

### hw/rtl/gradient_noise_3d_top.sv
// Channel   Dir  tdata                                         tuser
// s_axis    in   entry_index, entry_value, coord_x/y/z (112b)  kind
// m_axis    out  noise_value (18b, zero-padded to 24b)         -
// cfg       in   coordinate_scale (24b), written on cfg_we     -
//
// One evaluate transaction can enter every cycle while the output is not holding the
// pipeline. A load transaction is held off while an evaluation sits in the first
// three stages, which read the seven copies of the permutation table.
// Each stage advances on its own, so bubbles close up while the output waits.
// Reset clears valid bits and the scale register; the table has no reset pass.
module gradient_noise_3d_top #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [gn3d_pkg::SCALE_W-1:0]        cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // entry_index[7:0], entry_value[15:8], coord_x[47:16], coord_y[79:48], coord_z[111:80]
    input  logic [gn3d_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // kind[0]
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // noise_value[17:0], zeros above
    output logic [gn3d_pkg::M_TDATA_W-1:0]      m_axis_tdata
);
    import gn3d_pkg::*;

    localparam int F     = FRACTION_BITS;
    localparam int GW    = F + 3;
    localparam int IW    = F + 4;
    localparam int PW    = GW + F + 2;
    localparam int RW    = GW + 16;
    localparam int NSTG  = 12;
    localparam logic signed [GW-1:0] ONE_G = GW'(1) << F;
    localparam logic signed [RW-1:0] SAT_HI = RW'(OUT_MAX_C);
    localparam logic signed [RW-1:0] SAT_LO = RW'(OUT_MIN_C);

    function automatic logic signed [GW-1:0] grad(input cell_t h8,
                                                 input logic signed [GW-1:0] gx,
                                                 input logic signed [GW-1:0] gy,
                                                 input logic signed [GW-1:0] gz);
        logic [3:0] h;
        logic signed [GW-1:0] gu, gv;
        begin
            h  = h8[3:0];
            gu = (h < HASH_U_SPLIT) ? gx : gy;
            if (h < HASH_V_SPLIT) begin
                gv = gy;
            end else if (h == HASH_V_X_A || h == HASH_V_X_B) begin
                gv = gx;
            end else begin
                gv = gz;
            end
            grad = (h[0] ? -gu : gu) + (h[1] ? -gv : gv);
        end
    endfunction

    function automatic logic signed [PW-1:0] bprod(input logic [F-1:0] t,
                                                  input logic signed [GW-1:0] ga,
                                                  input logic signed [GW-1:0] gb);
        logic signed [GW:0] d;
        logic signed [F:0]  ts;
        begin
            d     = (GW+1)'(gb) - (GW+1)'(ga);
            ts    = $signed({1'b0, t});
            bprod = PW'(d) * PW'(ts);
        end
    endfunction

    function automatic logic signed [GW-1:0] bsum(input logic signed [GW-1:0] ga,
                                                 input logic signed [PW-1:0] p);
        logic signed [PW-1:0] sh;
        begin
            sh   = p >>> F;
            bsum = ga + sh[GW-1:0];
        end
    endfunction

    // Handshake and stage control.
    logic [NSTG:1]   v_reg;
    logic [NSTG+1:1] en;
    logic            s_fire, eval_fire, read_busy;
    logic [SCALE_W-1:0] scale_reg;

    always_comb begin
        en[NSTG+1] = m_axis_tready;
        for (int k = NSTG; k >= 1; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign read_busy     = v_reg[1] || v_reg[2] || v_reg[3];
    assign s_axis_tready = en[1] && (s_axis_tuser == KIND_EVAL || !read_busy);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign eval_fire     = s_fire && s_axis_tuser == KIND_EVAL;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg     <= '0;
            scale_reg <= SCALE_RESET;
        end else begin
            if (cfg_we) begin
                scale_reg <= cfg_wdata;
            end
            if (en[1]) begin
                v_reg[1] <= eval_fire;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (en[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // Stage 1: scale the coordinates.
    logic signed [PROD_W-1:0] px_reg [3];

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            for (int i = 0; i < 3; i++) begin
                px_reg[i] <= $signed(s_axis_tdata[16+COORD_W*i +: COORD_W])
                             * $signed({1'b0, scale_reg});
            end
        end
    end

    // Permutation table copies: copy 0 for the first hash, 1-2 for the second,
    // 3-6 for the corner hashes. A load writes all of them.
    cell_t tbl_mem [NUM_COPIES][TABLE_DEPTH];
    cell_t rd0_reg [NUM_COPIES];
    cell_t rd1_reg [NUM_COPIES];
    cell_t addr0 [NUM_COPIES];
    logic  ren [NUM_COPIES];

    logic [F-1:0]   fr1 [3];
    logic [2*F-1:0] sq1 [3];
    logic [F-1:0]   fr2_reg [3];
    logic [F-1:0]   t2_reg [3];
    cell_t          cy2_reg, cz2_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            fr1[i] = px_reg[i][31 -: F];
            sq1[i] = (2*F)'(fr1[i]) * (2*F)'(fr1[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            for (int i = 0; i < 3; i++) begin
                fr2_reg[i] <= fr1[i];
                t2_reg[i]  <= sq1[i][2*F-1:F];
            end
            cy2_reg <= px_reg[1][39:32];
            cz2_reg <= px_reg[2][39:32];
        end
    end

    // Stage 3: second hash level, t^3 and the inner fade polynomial.
    logic [2*F-1:0] cube2 [3];
    logic [IW-1:0]  inner2 [3];
    logic [F-1:0]   fr3_reg [3];
    logic [F-1:0]   t3_reg [3];
    logic [IW-1:0]  inner3_reg [3];
    cell_t          cz3_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cube2[i]  = (2*F)'(t2_reg[i]) * (2*F)'(fr2_reg[i]);
            inner2[i] = (IW'(t2_reg[i]) << 2) + (IW'(t2_reg[i]) << 1)
                        + (IW'(10) << F)
                        - ((IW'(fr2_reg[i]) << 4) - IW'(fr2_reg[i]));
        end
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            for (int i = 0; i < 3; i++) begin
                fr3_reg[i]    <= fr2_reg[i];
                t3_reg[i]     <= cube2[i][2*F-1:F];
                inner3_reg[i] <= inner2[i];
            end
            cz3_reg <= cz2_reg;
        end
    end

    always_comb begin
        addr0[0] = px_reg[0][39:32];
        addr0[1] = rd0_reg[0] + cy2_reg;
        addr0[2] = rd1_reg[0] + cy2_reg;
        addr0[3] = rd0_reg[1] + cz3_reg;
        addr0[4] = rd1_reg[1] + cz3_reg;
        addr0[5] = rd0_reg[2] + cz3_reg;
        addr0[6] = rd1_reg[2] + cz3_reg;
        ren[0]   = en[2];
        ren[1]   = en[3];
        ren[2]   = en[3];
        for (int c = 3; c < NUM_COPIES; c++) begin
            ren[c] = en[4];
        end
    end

    always_ff @(posedge aclk) begin
        for (int c = 0; c < NUM_COPIES; c++) begin
            if (s_fire && s_axis_tuser == KIND_LOAD) begin
                tbl_mem[c][s_axis_tdata[7:0]] <= s_axis_tdata[15:8];
            end
            if (ren[c]) begin
                rd0_reg[c] <= tbl_mem[c][addr0[c]];
                rd1_reg[c] <= tbl_mem[c][addr0[c] + cell_t'(1)];
            end
        end
    end

    // Stage 4: finish the fade.
    logic [2*F+3:0] fp3 [3];
    logic [F-1:0]   fr4_reg [3];
    logic [F-1:0]   fade4_reg [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            fp3[i] = (2*F+4)'(t3_reg[i]) * (2*F+4)'(inner3_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            for (int i = 0; i < 3; i++) begin
                fr4_reg[i]   <= fr3_reg[i];
                fade4_reg[i] <= fp3[i][2*F-1:F];
            end
        end
    end

    // Stage 5: corner gradients.
    logic signed [GW-1:0] px4, py4, pz4, mx4, my4, mz4;
    logic signed [GW-1:0] g5_reg [8];
    logic [F-1:0]         fade5_reg [3];

    always_comb begin
        px4 = $signed({3'b000, fr4_reg[0]});
        py4 = $signed({3'b000, fr4_reg[1]});
        pz4 = $signed({3'b000, fr4_reg[2]});
        mx4 = px4 - ONE_G;
        my4 = py4 - ONE_G;
        mz4 = pz4 - ONE_G;
    end

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            g5_reg[0] <= grad(rd0_reg[3], px4, py4, pz4);
            g5_reg[1] <= grad(rd0_reg[5], mx4, py4, pz4);
            g5_reg[2] <= grad(rd0_reg[4], px4, my4, pz4);
            g5_reg[3] <= grad(rd0_reg[6], mx4, my4, pz4);
            g5_reg[4] <= grad(rd1_reg[3], px4, py4, mz4);
            g5_reg[5] <= grad(rd1_reg[5], mx4, py4, mz4);
            g5_reg[6] <= grad(rd1_reg[4], px4, my4, mz4);
            g5_reg[7] <= grad(rd1_reg[6], mx4, my4, mz4);
            fade5_reg <= fade4_reg;
        end
    end

    // Stages 6 to 11: three interpolation levels, product then sum.
    logic signed [PW-1:0] p6_reg [4];
    logic signed [GW-1:0] a6_reg [4];
    logic [F-1:0]         fv6_reg, fw6_reg;
    logic signed [GW-1:0] l7_reg [4];
    logic [F-1:0]         fv7_reg, fw7_reg;
    logic signed [PW-1:0] p8_reg [2];
    logic signed [GW-1:0] a8_reg [2];
    logic [F-1:0]         fw8_reg;
    logic signed [GW-1:0] m9_reg [2];
    logic [F-1:0]         fw9_reg;
    logic signed [PW-1:0] p10_reg;
    logic signed [GW-1:0] a10_reg;
    logic signed [GW-1:0] r11_reg;

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            for (int j = 0; j < 4; j++) begin
                p6_reg[j] <= bprod(fade5_reg[0], g5_reg[2*j], g5_reg[2*j+1]);
                a6_reg[j] <= g5_reg[2*j];
            end
            fv6_reg <= fade5_reg[1];
            fw6_reg <= fade5_reg[2];
        end
        if (en[7]) begin
            for (int j = 0; j < 4; j++) begin
                l7_reg[j] <= bsum(a6_reg[j], p6_reg[j]);
            end
            fv7_reg <= fv6_reg;
            fw7_reg <= fw6_reg;
        end
        if (en[8]) begin
            for (int j = 0; j < 2; j++) begin
                p8_reg[j] <= bprod(fv7_reg, l7_reg[2*j], l7_reg[2*j+1]);
                a8_reg[j] <= l7_reg[2*j];
            end
            fw8_reg <= fw7_reg;
        end
        if (en[9]) begin
            for (int j = 0; j < 2; j++) begin
                m9_reg[j] <= bsum(a8_reg[j], p8_reg[j]);
            end
            fw9_reg <= fw8_reg;
        end
        if (en[10]) begin
            p10_reg <= bprod(fw9_reg, m9_reg[0], m9_reg[1]);
            a10_reg <= m9_reg[0];
        end
        if (en[11]) begin
            r11_reg <= bsum(a10_reg, p10_reg);
        end
    end

    // Stage 12: rescale to 16 fraction bits (floor) and saturate.
    logic signed [RW-1:0]  rs11;
    logic signed [OUT_W-1:0] out_next;
    logic signed [OUT_W-1:0] out12_reg;

    always_comb begin
        rs11 = $signed({r11_reg, 16'b0}) >>> F;
        priority if (rs11 > SAT_HI) begin
            out_next = OUT_W'(OUT_MAX_C);
        end else if (rs11 < SAT_LO) begin
            out_next = OUT_W'(OUT_MIN_C);
        end else begin
            out_next = rs11[OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[12]) begin
            out12_reg <= out_next;
        end
    end

    assign m_axis_tvalid = v_reg[NSTG];
    assign m_axis_tdata  = {{(M_TDATA_W-OUT_W){1'b0}}, out12_reg};

`ifndef SYNTHESIS
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_axis_tuser == KIND_LOAD) |-> !read_busy)
        else $error("table written while an evaluation still reads it");

    a_eval_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        eval_fire |=> v_reg[1])
        else $error("accepted evaluation missing from first stage");

    a_ready_room: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> en[1])
        else $error("input ready without room in first stage");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[5] && !en[6]) |=> (v_reg[5] && $stable(g5_reg[0])))
        else $error("stalled gradient stage lost its contents");
`endif

endmodule

### tb/sv/tb_gradient_noise_3d_top.sv
module tb_gradient_noise_3d_top;
    import gn3d_pkg::*;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [SCALE_W-1:0]    cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;

    gradient_noise_3d_top u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    localparam int FRAC      = 16;
    localparam int LATENCY   = 16;
    localparam int STALL_MAX = 5000;

    typedef struct packed {
        logic              kind;
        logic [7:0]        idx;
        logic [7:0]        val;
        logic [31:0]       x;
        logic [31:0]       y;
        logic [31:0]       z;
        logic              typed;
        logic [OUT_W-1:0]  noise;
    } probe_t;

    // Integer coordinates make every fraction zero, so the noise must be zero there.
    probe_t probes [] = '{
        '{KIND_EVAL, 8'h00, 8'h00, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 18'd0},
        '{KIND_EVAL, 8'h00, 8'h00, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 18'd0},
        '{KIND_EVAL, 8'h00, 8'h00, 32'h0001_0000, 32'h0002_0000, 32'h7FFF_0000, 1'b1, 18'd0},
        '{KIND_EVAL, 8'h00, 8'h00, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 18'd0},
        '{KIND_EVAL, 8'h00, 8'h00, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 1'b0, 18'd0},
        '{KIND_EVAL, 8'h00, 8'h00, 32'hFFFF_8000, 32'hFFFF_8000, 32'hFFFF_8000, 1'b0, 18'd0},
        '{KIND_EVAL, 8'h00, 8'h00, 32'h0000_FFFF, 32'hFFFF_0001, 32'h0123_4567, 1'b0, 18'd0},
        '{KIND_LOAD, 8'h00, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 18'd0},
        '{KIND_LOAD, 8'hFF, 8'h00, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 18'd0},
        '{KIND_EVAL, 8'hFF, 8'hFF, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 1'b0, 18'd0},
        '{KIND_EVAL, 8'h00, 8'h00, 32'h00FF_8000, 32'h00FF_C000, 32'h00FF_4000, 1'b0, 18'd0},
        '{KIND_EVAL, 8'h00, 8'h00, 32'h1234_5678, 32'hEDCB_A987, 32'h7654_3210, 1'b0, 18'd0},
        '{KIND_EVAL, 8'h00, 8'h00, 32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0001, 1'b0, 18'd0},
        '{KIND_LOAD, 8'h80, 8'h80, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 18'd0},
        '{KIND_EVAL, 8'h00, 8'h00, 32'h007F_E000, 32'h0080_2000, 32'hFF80_1000, 1'b0, 18'd0}
    };

    logic [7:0]         perm_copy [256];
    logic [SCALE_W-1:0] scale_copy;
    logic [OUT_W-1:0]   noise_due [$];
    int                 mismatch_count = 0;
    int                 quiet_cycles = 0;
    bit                 calm;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    task automatic report(input string msg);
        $display("MISMATCH: %s", msg);
        mismatch_count++;
    endtask

    function automatic longint perm_at(input longint i);
        return longint'(perm_copy[i & 255]);
    endfunction

    function automatic longint fade(input longint t);
        longint t2, t3;
        t2 = (t * t) >>> FRAC;
        t3 = (t2 * t) >>> FRAC;
        return (t3 * (6 * t2 + 10 * (longint'(1) << FRAC) - 15 * t)) >>> FRAC;
    endfunction

    function automatic longint grad(input longint h, input longint x, input longint y,
                                    input longint z);
        logic [3:0] h4;
        longint     u, v;
        h4 = h[3:0];
        u  = (h4 < HASH_U_SPLIT) ? x : y;
        v  = (h4 < HASH_V_SPLIT) ? y : ((h4 == HASH_V_X_A || h4 == HASH_V_X_B) ? x : z);
        return (h4[0] ? -u : u) + (h4[1] ? -v : v);
    endfunction

    function automatic longint mix(input longint t, input longint a, input longint b);
        return a + (((b - a) * t) >>> FRAC);
    endfunction

    function automatic logic [OUT_W-1:0] noise_at(input logic [31:0] px, input logic [31:0] py,
                                                   input logic [31:0] pz);
        longint p [3];
        longint c [3];
        longint f [3];
        longint one, u, v, w, a, b, aa, ab, ba, bb, r;
        one = longint'(1) << FRAC;
        p[0] = longint'($signed(px)) * longint'({40'b0, scale_copy});
        p[1] = longint'($signed(py)) * longint'({40'b0, scale_copy});
        p[2] = longint'($signed(pz)) * longint'({40'b0, scale_copy});
        for (int i = 0; i < 3; i++) begin
            c[i] = longint'(p[i][39:32]);
            f[i] = longint'(p[i][31:32-FRAC]);
        end
        u  = fade(f[0]);
        v  = fade(f[1]);
        w  = fade(f[2]);
        a  = perm_at(c[0]) + c[1];
        b  = perm_at(c[0] + 1) + c[1];
        aa = perm_at(a) + c[2];
        ab = perm_at(a + 1) + c[2];
        ba = perm_at(b) + c[2];
        bb = perm_at(b + 1) + c[2];
        r = mix(w,
                mix(v,
                    mix(u, grad(perm_at(aa), f[0], f[1], f[2]),
                           grad(perm_at(ba), f[0] - one, f[1], f[2])),
                    mix(u, grad(perm_at(ab), f[0], f[1] - one, f[2]),
                           grad(perm_at(bb), f[0] - one, f[1] - one, f[2]))),
                mix(v,
                    mix(u, grad(perm_at(aa + 1), f[0], f[1], f[2] - one),
                           grad(perm_at(ba + 1), f[0] - one, f[1], f[2] - one)),
                    mix(u, grad(perm_at(ab + 1), f[0], f[1] - one, f[2] - one),
                           grad(perm_at(bb + 1), f[0] - one, f[1] - one, f[2] - one))));
        r = r >>> (FRAC - 16);
        if (r > OUT_MAX_C) r = OUT_MAX_C;
        if (r < OUT_MIN_C) r = OUT_MIN_C;
        return r[OUT_W-1:0];
    endfunction

    // Presents one transaction and waits for it to be taken; the prediction is made
    // at acceptance so it sees the table exactly as the block does.
    task automatic push_item(input probe_t it);
        while (!calm && $urandom_range(99) < 23) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.kind;
        s_axis_tdata  <= {it.z, it.y, it.x, it.val, it.idx};
        do @(posedge aclk); while (!(s_axis_tvalid && s_axis_tready));
        if (it.kind == KIND_LOAD) begin
            perm_copy[it.idx] = it.val;
        end else if (it.typed) begin
            noise_due.push_back(it.noise);
        end else begin
            noise_due.push_back(noise_at(it.x, it.y, it.z));
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (noise_due.size() != 0) @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);
    endtask

    task automatic set_scale(input logic [SCALE_W-1:0] s);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= s;
        @(posedge aclk);
        cfg_we     <= 1'b0;
        scale_copy  = s;
    endtask

    function automatic logic [31:0] pick_coord();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(3))
            0: return r;
            1: return {{13{r[18]}}, r[18:0]};
            2: return {r[31:16], 16'h0000} + {{29{r[2]}}, r[2:0]};
            default: return {r[31:16], r[15] ? 16'hFFFF : 16'h0000} ^ {16'h0, r[7:0], 8'h0};
        endcase
    endfunction

    function automatic probe_t random_item();
        probe_t it;
        logic [31:0] r;
        r        = $urandom;
        it.kind  = ($urandom_range(99) < 20) ? KIND_LOAD : KIND_EVAL;
        it.idx   = r[7:0];
        it.val   = r[15:8];
        it.x     = pick_coord();
        it.y     = pick_coord();
        it.z     = pick_coord();
        it.typed = 1'b0;
        it.noise = '0;
        return it;
    endfunction

    always @(posedge aclk) begin
        m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 23);
    end

    always @(posedge aclk) begin
        logic [OUT_W-1:0] want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (noise_due.size() == 0) begin
                report($sformatf("unexpected result %h", m_axis_tdata));
            end else begin
                want = noise_due.pop_front();
                if (m_axis_tdata !== {{(M_TDATA_W-OUT_W){1'b0}}, want}) begin
                    report($sformatf("noise_value got %h want %h", m_axis_tdata, want));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_MAX) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        logic [SCALE_W-1:0] phase_scale [5];
        probe_t             it;
        calm           = 1'b0;
        scale_copy     = SCALE_RESET;
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = KIND_LOAD;
        m_axis_tready  = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // The whole table must hold known values before the first evaluation.
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            it       = random_item();
            it.kind  = KIND_LOAD;
            it.idx   = i[7:0];
            push_item(it);
        end

        foreach (probes[i]) push_item(probes[i]);

        phase_scale[0] = '0;
        phase_scale[1] = {SCALE_W{1'b1}};
        phase_scale[2] = SCALE_RESET;
        phase_scale[3] = SCALE_W'($urandom);
        phase_scale[4] = 24'd3000;
        for (int ph = 0; ph < 5; ph++) begin
            set_scale(phase_scale[ph]);
            for (int n = 0; n < 290; n++) begin
                calm = (ph == 3 && n < 150);
                if (ph == 2 && n == 145) drain();
                push_item(random_item());
            end
        end
        calm = 1'b0;

        drain();
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
